// ----- sv/bps_pkg.sv -----
// ============================================================================
// bps_pkg: shared types, constants and table builders for the shader
// Holds register indexes, the power select code, pipeline stage counts and
// the elaboration-time functions that build the log2 and exp2 tables.
// ============================================================================
`default_nettype none

package bps_pkg;

    // Quotient bits of the normalizer divide (Q2.14 magnitude up to 1.0)
    localparam int QUOT_BITS = 15;
    // Normalizer stages apart from the square root: abs, square, sum, divide, sign
    localparam int NORM_EXTRA_STAGES = QUOT_BITS + 4;

    localparam logic [14:0] ONE_Q14 = 15'd16384;

    typedef enum logic [2:0] {
        CFG_AMBIENT_COLOR  = 3'd0,
        CFG_LIGHT_COLOR    = 3'd1,
        CFG_LIGHT_DIR      = 3'd2,
        CFG_AMBIENT_REFL   = 3'd3,
        CFG_DIFFUSE_REFL   = 3'd4,
        CFG_SPECULAR_REFL  = 3'd5,
        CFG_SHININESS      = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        POW_ZERO,
        POW_ONE,
        POW_CALC
    } t_pow_sel;

    // Integer square root, used only while building tables
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(y) fraction in Q.16 by repeated squaring; y is Q2.30 in [1,2)
    function automatic logic [15:0] log_entry(input logic [63:0] y_in);
        logic [63:0] y;
        logic [15:0] r;
        int          b;
        y = y_in;
        r = '0;
        for (b = 15; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                r[b] = 1'b1;
                y    = y >> 1;
            end
        end
        return r;
    endfunction

    // 2^(-g/65536) in Q.30 as a product of 2^(-2^-k) factors
    function automatic logic [30:0] exp_entry(input logic [63:0] g);
        logic [63:0] root [17];
        logic [63:0] v;
        int          k;
        root[0] = 64'd1 << 29;
        for (k = 1; k <= 16; k++) root[k] = isqrt64(root[k-1] << 30);
        v = 64'd1 << 30;
        for (k = 1; k <= 16; k++) begin
            if (g[16-k]) v = (v * root[k]) >> 30;
        end
        return v[30:0];
    endfunction

    // Clamp a Q4.28 dot product to a Q2.14 value in [0, 1.0]
    function automatic logic [14:0] clamp_dot(input logic signed [33:0] s);
        logic [19:0] r;
        r = 20'(s >>> 14);
        if (s <= 0) return '0;
        if (r > 20'(ONE_Q14)) return ONE_Q14;
        return r[14:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/bps_stream_if.sv -----
// ============================================================================
// bps_stream_if: valid/ready channels of the shader
// Normal channel into the block and color channel out of it.
// ============================================================================
`default_nettype none

interface bps_normal_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] normal_x;
    logic signed [W-1:0] normal_y;
    logic signed [W-1:0] normal_z;

    modport source(output valid, output normal_x, output normal_y, output normal_z,
                   input ready);
    modport sink(input valid, input normal_x, input normal_y, input normal_z,
                 output ready);
endinterface

interface bps_color_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;

    modport source(output valid, output red, output green, output blue, input ready);
    modport sink(input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- sv/bps_norm.sv -----
// ============================================================================
// bps_norm: pipelined vector normalizer
// Normalizes VECS signed 3-vectors to Q2.14: squares, sum, one root bit per
// stage, then one quotient bit per stage of |v|*2^14/len, then sign.
// ============================================================================
`default_nettype none

module bps_norm #(
    parameter int W    = 16,
    parameter int VECS = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [VECS-1:0][2:0][W-1:0]  i_vec,
    output logic                              o_valid,
    output logic [VECS-1:0][2:0][15:0]        o_unit,
    output logic [VECS-1:0]                   o_ok
);

    localparam int SW  = 2 * W;
    localparam int RW  = W + 2;
    localparam int DW  = W + 1;
    localparam int QB  = bps_pkg::QUOT_BITS;
    localparam int LAT = W + bps_pkg::NORM_EXTRA_STAGES;

    logic r_vld [LAT];

    // Advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) r_vld[s] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < LAT; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    assign o_valid = r_vld[LAT-1];

    for (genvar gv = 0; gv < VECS; gv++) begin : g_vec
        logic [2:0]            r_sgn [LAT-1];
        logic [2:0][W-1:0]     r_a_mag;
        logic [2:0][SW-1:0]    r_b_sq;
        logic [2:0][W-1:0]     r_b_mag;
        logic [SW-1:0]         r_c_sum;
        logic [2:0][W-1:0]     r_c_mag;
        logic [RW-1:0]         r_s_rem  [W];
        logic [W-1:0]          r_s_root [W];
        logic [SW-1:0]         r_s_x    [W];
        logic [2:0][W-1:0]     r_s_mag  [W];
        logic [2:0][DW-1:0]    r_d_rem  [QB];
        logic [2:0][QB-1:0]    r_d_q    [QB];
        logic [W-1:0]          r_d_len  [QB];
        logic [2:0][15:0]      r_f_unit;
        logic                  r_f_ok;

        // Hold signs, take magnitudes, square and sum
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int c = 0; c < 3; c++) begin
                    r_sgn[0][c] <= i_vec[gv][c][W-1];
                    r_a_mag[c]  <= i_vec[gv][c][W-1] ? (~i_vec[gv][c] + W'(1))
                                                     : i_vec[gv][c];
                    r_b_sq[c]   <= SW'(r_a_mag[c]) * SW'(r_a_mag[c]);
                end
                for (int s = 1; s < LAT-1; s++) r_sgn[s] <= r_sgn[s-1];
                r_b_mag <= r_a_mag;
                r_c_sum <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
                r_c_mag <= r_b_mag;
            end
        end

        // Square root, one result bit per stage
        for (genvar gk = 0; gk < W; gk++) begin : g_sqrt
            logic [RW-1:0]     w_rem;
            logic [W-1:0]      w_root;
            logic [SW-1:0]     w_x;
            logic [2:0][W-1:0] w_mag;
            logic [RW+1:0]     w_cur;
            logic [RW+1:0]     w_try;

            if (gk == 0) begin : g_first
                assign w_rem  = '0;
                assign w_root = '0;
                assign w_x    = r_c_sum;
                assign w_mag  = r_c_mag;
            end else begin : g_next
                assign w_rem  = r_s_rem[gk-1];
                assign w_root = r_s_root[gk-1];
                assign w_x    = r_s_x[gk-1];
                assign w_mag  = r_s_mag[gk-1];
            end

            assign w_cur = {w_rem, w_x[SW-1 -: 2]};
            assign w_try = (RW+2)'({w_root, 2'b01});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_cur >= w_try) begin
                        r_s_rem[gk]  <= RW'(w_cur - w_try);
                        r_s_root[gk] <= {w_root[W-2:0], 1'b1};
                    end else begin
                        r_s_rem[gk]  <= w_cur[RW-1:0];
                        r_s_root[gk] <= {w_root[W-2:0], 1'b0};
                    end
                    r_s_x[gk]   <= w_x << 2;
                    r_s_mag[gk] <= w_mag;
                end
            end
        end

        // Divide magnitudes by the length, one quotient bit per stage
        for (genvar gj = 0; gj < QB; gj++) begin : g_div
            logic [2:0][DW-1:0] w_rin;
            logic [2:0][QB-1:0] w_qin;
            logic [W-1:0]       w_len;

            if (gj == 0) begin : g_first
                assign w_len = r_s_root[W-1];
                for (genvar gc = 0; gc < 3; gc++) begin : g_c
                    assign w_rin[gc] = DW'(r_s_mag[W-1][gc]);
                    assign w_qin[gc] = '0;
                end
            end else begin : g_next
                assign w_len = r_d_len[gj-1];
                for (genvar gc = 0; gc < 3; gc++) begin : g_c
                    assign w_rin[gc] = {r_d_rem[gj-1][gc][DW-2:0], 1'b0};
                    assign w_qin[gc] = r_d_q[gj-1][gc];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d_len[gj] <= w_len;
                    for (int c = 0; c < 3; c++) begin
                        if (w_rin[c] >= DW'(w_len)) begin
                            r_d_rem[gj][c] <= w_rin[c] - DW'(w_len);
                            r_d_q[gj][c]   <= w_qin[c] | (QB'(1) << (QB-1-gj));
                        end else begin
                            r_d_rem[gj][c] <= w_rin[c];
                            r_d_q[gj][c]   <= w_qin[c];
                        end
                    end
                end
            end
        end

        // Apply signs; zero length gives the zero vector
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_f_ok <= (r_d_len[QB-1] != '0);
                for (int c = 0; c < 3; c++) begin
                    if (r_d_len[QB-1] == '0) begin
                        r_f_unit[c] <= '0;
                    end else if (r_sgn[LAT-2][c]) begin
                        r_f_unit[c] <= 16'(-16'(r_d_q[QB-1][c]));
                    end else begin
                        r_f_unit[c] <= 16'(r_d_q[QB-1][c]);
                    end
                end
            end
        end

        assign o_unit[gv] = r_f_unit;
        assign o_ok[gv]   = r_f_ok;
    end

endmodule

`default_nettype wire

// ----- sv/blinn_phong_directional_shader.sv -----
// Throughput: one transaction per cycle while the output is not stalled; the
// square root and divide of the three normalizers are unrolled one bit per
// stage, so the depth follows them. A stall at the output freezes the whole
// pipeline; nothing is dropped. Reset (synchronous, active low) clears all
// valid bits and loads the register defaults; the block takes transactions
// as soon as reset is released.
// ============================================================================
// blinn_phong_directional_shader: fixed-point Blinn-Phong, one directional light
// Normalizes N and L, forms and normalizes H, evaluates the clamped dot
// products, the specular power through log2/exp2 tables and the color sum.
// ============================================================================
`default_nettype none

module blinn_phong_directional_shader #(
    parameter int NORMAL_WIDTH      = 16,
    parameter int POW_TABLE_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bps_normal_if.sink       i_normal,
    bps_color_if.source      o_color,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data
);

    localparam int NW    = NORMAL_WIDTH;
    localparam int VW    = (NW > 16) ? NW : 16;
    localparam int IW    = $clog2(POW_TABLE_ENTRIES);
    localparam int H_LAT = 16 + bps_pkg::NORM_EXTRA_STAGES;

    // ------------------------------------------------------------------ config
    logic [47:0] r_amb_color;
    logic [47:0] r_light_color;
    logic [47:0] r_light_dir;
    logic [47:0] r_ka;
    logic [47:0] r_kd;
    logic [47:0] r_ks;
    logic [15:0] r_ns;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amb_color   <= 48'h333333333333;
            r_light_color <= 48'h4CCD4CCD4CCD;
            r_light_dir   <= 48'h4000C0000000;
            r_ka          <= '0;
            r_kd          <= '0;
            r_ks          <= '0;
            r_ns          <= 16'd8192;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bps_pkg::CFG_AMBIENT_COLOR: r_amb_color   <= i_cfg_data;
                bps_pkg::CFG_LIGHT_COLOR:   r_light_color <= i_cfg_data;
                bps_pkg::CFG_LIGHT_DIR:     r_light_dir   <= i_cfg_data;
                bps_pkg::CFG_AMBIENT_REFL:  r_ka          <= i_cfg_data;
                bps_pkg::CFG_DIFFUSE_REFL:  r_kd          <= i_cfg_data;
                bps_pkg::CFG_SPECULAR_REFL: r_ks          <= i_cfg_data;
                bps_pkg::CFG_SHININESS:     r_ns          <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------ tables
    logic [15:0] log_rom [POW_TABLE_ENTRIES];
    logic [30:0] exp_rom [POW_TABLE_ENTRIES];

    for (genvar gi = 0; gi < POW_TABLE_ENTRIES; gi++) begin : g_rom
        assign log_rom[gi] = bps_pkg::log_entry((64'd1 << 30) +
                                 ((64'(gi) << 30) / POW_TABLE_ENTRIES));
        assign exp_rom[gi] = bps_pkg::exp_entry((64'(gi) << 16) / POW_TABLE_ENTRIES);
    end

    // ------------------------------------------------------------------ flow
    logic en;
    logic r_p10_vld;

    assign en             = !r_p10_vld || o_color.ready;
    assign i_normal.ready = en;

    // ------------------------------------------------------------------ N and L
    logic [1:0][2:0][VW-1:0] nl_vec;
    logic                    nl_valid;
    logic [1:0][2:0][15:0]   nl_unit;
    logic [1:0]              nl_ok;

    for (genvar gc = 0; gc < 3; gc++) begin : g_nlin
        assign nl_vec[1][gc] = VW'($signed(r_light_dir[16*gc +: 16]));
    end
    assign nl_vec[0][0] = VW'($signed(i_normal.normal_x));
    assign nl_vec[0][1] = VW'($signed(i_normal.normal_y));
    assign nl_vec[0][2] = VW'($signed(i_normal.normal_z));

    bps_norm #(.W(VW), .VECS(2)) u_norm_nl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_normal.valid),
        .i_vec   (nl_vec),
        .o_valid (nl_valid),
        .o_unit  (nl_unit),
        .o_ok    (nl_ok)
    );

    // ------------------------------------------------------------------ H
    logic [0:0][2:0][15:0] h_vec;
    logic                  h_valid;
    logic [0:0][2:0][15:0] h_unit;
    logic [0:0]            h_ok;

    assign h_vec[0][0] = nl_unit[1][0];
    assign h_vec[0][1] = nl_unit[1][1];
    assign h_vec[0][2] = nl_unit[1][2] - 16'd16384;

    bps_norm #(.W(16), .VECS(1)) u_norm_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (nl_valid),
        .i_vec   (h_vec),
        .o_valid (h_valid),
        .o_unit  (h_unit),
        .o_ok    (h_ok)
    );

    // Delay N, L and their flags alongside the H normalizer
    logic [97:0] r_hd [H_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd[0] <= {nl_ok[1], nl_ok[0], nl_unit[1], nl_unit[0]};
            for (int s = 1; s < H_LAT; s++) r_hd[s] <= r_hd[s-1];
        end
    end

    logic [2:0][15:0] d_n;
    logic [2:0][15:0] d_l;
    logic             d_nok;
    logic             d_lok;

    assign d_n   = r_hd[H_LAT-1][47:0];
    assign d_l   = r_hd[H_LAT-1][95:48];
    assign d_nok = r_hd[H_LAT-1][96];
    assign d_lok = r_hd[H_LAT-1][97];

    // ------------------------------------------------------------------ shading
    logic                        r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    logic                        r_p5_vld, r_p6_vld, r_p7_vld, r_p8_vld, r_p9_vld;
    logic signed [2:0][31:0]     r_p1_dl, r_p1_dh;
    logic                        r_p1_ok, r_p1_lok;
    logic [14:0]                 r_p2_lamb, r_p2_x;
    logic                        r_p2_ok;
    logic [14:0]                 r_p3_lamb, r_p4_lamb, r_p5_lamb, r_p6_lamb, r_p7_lamb;
    bps_pkg::t_pow_sel           r_p3_sel, r_p4_sel, r_p5_sel, r_p6_sel;
    logic [3:0]                  r_p3_e;
    logic [IW-1:0]               r_p3_idx;
    logic [19:0]                 r_p4_nl;
    logic [27:0]                 r_p5_t;
    logic [3:0]                  r_p6_ti;
    logic [IW-1:0]               r_p6_idx;
    logic [14:0]                 r_p7_int;
    logic [2:0][15:0]            r_p8_amb, r_p8_dl, r_p8_spe;
    logic [2:0][15:0]            r_p9_amb, r_p9_dif, r_p9_spe;
    logic [2:0][15:0]            r_p10_col;

    // Combinational helpers for the power stages
    bps_pkg::t_pow_sel n_p3_sel;
    logic [3:0]        n_p3_e;
    logic [13:0]       n_p3_mant;
    logic [30:0]       n_p7_val;
    logic [14:0]       n_p7_int;
    logic [2:0][17:0]  n_p10_sum;

    // Classify N.H and find the leading one
    always_comb begin
        n_p3_e = '0;
        for (int i = 0; i < 14; i++) begin
            if (r_p2_x[i]) n_p3_e = 4'(13 - i);
        end
        n_p3_mant = 14'(r_p2_x << n_p3_e);
        if (!r_p2_ok) begin
            n_p3_sel = bps_pkg::POW_ZERO;
        end else if (r_ns == '0) begin
            n_p3_sel = bps_pkg::POW_ONE;
        end else if (r_p2_x == '0) begin
            n_p3_sel = bps_pkg::POW_ZERO;
        end else if (r_p2_x >= bps_pkg::ONE_Q14) begin
            n_p3_sel = bps_pkg::POW_ONE;
        end else begin
            n_p3_sel = bps_pkg::POW_CALC;
        end
    end

    // Pick the specular intensity
    always_comb begin
        n_p7_val = exp_rom[r_p6_idx] >> (5'd16 + 5'(r_p6_ti));
        case (r_p6_sel)
            bps_pkg::POW_ONE:  n_p7_int = bps_pkg::ONE_Q14;
            bps_pkg::POW_CALC: n_p7_int = n_p7_val[14:0];
            default:           n_p7_int = '0;
        endcase
    end

    // Sum the three terms
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_p10_sum[c] = 18'(r_p9_amb[c]) + 18'(r_p9_dif[c]) + 18'(r_p9_spe[c]);
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_p7_vld  <= 1'b0;
            r_p8_vld  <= 1'b0;
            r_p9_vld  <= 1'b0;
            r_p10_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld  <= h_valid;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= r_p4_vld;
            r_p6_vld  <= r_p5_vld;
            r_p7_vld  <= r_p6_vld;
            r_p8_vld  <= r_p7_vld;
            r_p9_vld  <= r_p8_vld;
            r_p10_vld <= r_p9_vld;
        end
    end

    // Advance the shading datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            // Dot product terms
            for (int c = 0; c < 3; c++) begin
                r_p1_dl[c] <= $signed(d_n[c]) * $signed(d_l[c]);
                r_p1_dh[c] <= $signed(d_n[c]) * $signed(h_unit[0][c]);
            end
            r_p1_ok  <= d_nok && h_ok[0];
            r_p1_lok <= d_lok;

            // Sum and clamp
            r_p2_lamb <= r_p1_lok ? bps_pkg::clamp_dot(34'($signed(r_p1_dl[0]))
                                                      + 34'($signed(r_p1_dl[1]))
                                                      + 34'($signed(r_p1_dl[2]))) : '0;
            r_p2_x    <= bps_pkg::clamp_dot(34'($signed(r_p1_dh[0]))
                                            + 34'($signed(r_p1_dh[1]))
                                            + 34'($signed(r_p1_dh[2])));
            r_p2_ok   <= r_p1_ok;

            // Table index from the mantissa
            r_p3_lamb <= r_p2_lamb;
            r_p3_sel  <= n_p3_sel;
            r_p3_e    <= n_p3_e;
            r_p3_idx  <= IW'((26'(n_p3_mant[12:0]) * 26'(POW_TABLE_ENTRIES)) >> 13);

            // Negative log2
            r_p4_lamb <= r_p3_lamb;
            r_p4_sel  <= r_p3_sel;
            r_p4_nl   <= ((20'(r_p3_e) + 20'd1) << 16) - 20'(log_rom[r_p3_idx]);

            // Scale by the exponent
            r_p5_lamb <= r_p4_lamb;
            r_p5_sel  <= r_p4_sel;
            r_p5_t    <= 28'((36'(r_p4_nl) * 36'(r_ns)) >> 8);

            // Split into integer and fraction
            r_p6_lamb <= r_p5_lamb;
            r_p6_sel  <= (r_p5_sel == bps_pkg::POW_CALC && r_p5_t[27:16] >= 12'd15)
                         ? bps_pkg::POW_ZERO : r_p5_sel;
            r_p6_ti   <= r_p5_t[19:16];
            r_p6_idx  <= IW'((32'(r_p5_t[15:0]) * 32'(POW_TABLE_ENTRIES)) >> 16);

            // Intensity
            r_p7_lamb <= r_p6_lamb;
            r_p7_int  <= n_p7_int;

            // Per channel products
            for (int c = 0; c < 3; c++) begin
                r_p8_amb[c] <= 16'((32'(r_amb_color[16*c +: 16]) * 32'(r_ka[16*c +: 16]))
                                   >> 16);
                r_p8_dl[c]  <= 16'((31'(r_p7_lamb) * 31'(r_light_color[16*c +: 16])) >> 15);
                r_p8_spe[c] <= 16'((31'(r_p7_int) * 31'(r_ks[16*c +: 16])) >> 15);
            end

            // Diffuse reflectance
            for (int c = 0; c < 3; c++) begin
                r_p9_dif[c] <= 16'((32'(r_kd[16*c +: 16]) * 32'(r_p8_dl[c])) >> 16);
            end
            r_p9_amb <= r_p8_amb;
            r_p9_spe <= r_p8_spe;

            // Saturate into the output register
            for (int c = 0; c < 3; c++) begin
                r_p10_col[c] <= (n_p10_sum[c] > 18'hFFFF) ? 16'hFFFF : n_p10_sum[c][15:0];
            end
        end
    end

    assign o_color.valid = r_p10_vld;
    assign o_color.red   = r_p10_col[0];
    assign o_color.green = r_p10_col[1];
    assign o_color.blue  = r_p10_col[2];

endmodule

`default_nettype wire
